// ===== rtl/core/crc_cw_pkg.sv =====
`timescale 1ns / 1ps

package crc_cw_pkg;

	// Default for the widest generator the datapath is built for
	localparam int MAX_DEGREE_DEF = 16;

	localparam int NIBBLE_BITS = 4;
	localparam int BYTE_BITS   = 8;

	// Output field widths
	localparam int FIRST_W  = 24;
	localparam int SECOND_W = 20;
	localparam int LEN_W    = 5;

	// Register file
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam int TAIL_W  = 16;
	localparam int DEG_W   = 5;

	localparam logic [1:0] REG_TAIL   = 2'd0;
	localparam logic [1:0] REG_DEGREE = 2'd1;
	localparam logic [1:0] REG_MODE   = 2'd2;

	localparam logic [TAIL_W-1:0] TAIL_RST   = 16'd7;
	localparam logic [DEG_W-1:0]  DEGREE_RST = 5'd3;
	localparam logic              MODE_RST   = 1'b1;

	localparam logic MODE_NIBBLE = 1'b0;
	localparam logic MODE_BYTE   = 1'b1;

	typedef struct packed {
		logic [FIRST_W-1:0]  first_codeword;
		logic [SECOND_W-1:0] second_codeword;
		logic                second_valid;
		logic [LEN_W-1:0]    codeword_length;
	} cw_result_t;

endpackage

// ===== rtl/core/crc_codeword_encoder.sv =====
`timescale 1ns / 1ps

// Channel    | Direction | Handshake             | Payload
// -----------+-----------+-----------------------+---------------------------------------------
// byte       | in        | byte_valid/byte_ready | data_byte
// codeword   | out       | cw_valid/cw_ready     | first_codeword, second_codeword,
//            |           |                       | second_valid, codeword_length
// config     | in        | APB (psel/penable)    | paddr, pwdata, prdata (tail, degree, mode)
//
// One request per cycle while cw_ready is high; input register, then result register.
// The modulo-2 division, eight steps for a full byte, is unrolled between both registers.
// arst_n clears the valid flags and loads tail 7, degree 3, 8-bit mode.
// A stalled result only holds back the input register once that register is also full.

module crc_codeword_encoder #(
	parameter int MAX_DEGREE = crc_cw_pkg::MAX_DEGREE_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// byte requests
	input  logic                                byte_valid,
	output logic                                byte_ready,
	input  logic [crc_cw_pkg::BYTE_BITS-1:0]    data_byte,
	// codeword results
	output logic                                cw_valid,
	input  logic                                cw_ready,
	output logic [crc_cw_pkg::FIRST_W-1:0]      first_codeword,
	output logic [crc_cw_pkg::SECOND_W-1:0]     second_codeword,
	output logic                                second_valid,
	output logic [crc_cw_pkg::LEN_W-1:0]        codeword_length,
	// configuration
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [crc_cw_pkg::PADDR_W-1:0]      paddr,
	input  logic [crc_cw_pkg::PDATA_W-1:0]      pwdata,
	output logic [crc_cw_pkg::PDATA_W-1:0]      prdata,
	output logic                                pready
);

	// Remainder register width and width of an effective degree (1..MAX_DEGREE)
	localparam int RW = MAX_DEGREE;
	localparam int DW = $clog2(MAX_DEGREE + 1);
	// Full codeword before trimming to the output fields
	localparam int CW = crc_cw_pkg::BYTE_BITS + RW;

	// ------------------------------------------------------------------
	// Registers
	// ------------------------------------------------------------------
	logic [crc_cw_pkg::TAIL_W-1:0] generator_tail_q;
	logic [crc_cw_pkg::DEG_W-1:0]  generator_degree_q;
	logic                          dataword_mode_q;
	logic                          cfg_wr;
	logic [1:0]                    reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			generator_tail_q   <= crc_cw_pkg::TAIL_RST;
			generator_degree_q <= crc_cw_pkg::DEGREE_RST;
			dataword_mode_q    <= crc_cw_pkg::MODE_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				crc_cw_pkg::REG_TAIL:   generator_tail_q   <= pwdata[crc_cw_pkg::TAIL_W-1:0];
				crc_cw_pkg::REG_DEGREE: generator_degree_q <= pwdata[crc_cw_pkg::DEG_W-1:0];
				crc_cw_pkg::REG_MODE:   dataword_mode_q    <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			crc_cw_pkg::REG_TAIL:   prdata = 32'(generator_tail_q);
			crc_cw_pkg::REG_DEGREE: prdata = 32'(generator_degree_q);
			crc_cw_pkg::REG_MODE:   prdata = 32'(dataword_mode_q);
			default:                prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Effective degree: zero counts as one, anything above MAX_DEGREE saturates
	// ------------------------------------------------------------------
	logic [DW-1:0] deg_eff;
	logic [DW-1:0] align_sh;   // RW - deg_eff, puts the remainder MSB at bit RW-1
	logic [RW-1:0] tail_al;

	always_comb begin
		if (generator_degree_q == '0)
			deg_eff = DW'(1);
		else if ({1'b0, generator_degree_q} > 6'(MAX_DEGREE))
			deg_eff = DW'(MAX_DEGREE);
		else
			deg_eff = DW'(generator_degree_q);
		align_sh = DW'(RW) - deg_eff;
		// the left shift also drops tail bits at or above the degree
		tail_al  = RW'(generator_tail_q) << align_sh;
	end

	// MSB-aligned LFSR division; lo_only restricts it to the low nibble
	function automatic logic [RW-1:0] div_rem(
		input logic [crc_cw_pkg::BYTE_BITS-1:0] word,
		input logic                             lo_only,
		input logic [RW-1:0]                    tail_a
	);
		logic [RW-1:0] r;
		logic          fb;
		r = '0;
		for (int i = crc_cw_pkg::BYTE_BITS - 1; i >= 0; i--) begin
			if (!lo_only || i < crc_cw_pkg::NIBBLE_BITS) begin
				fb = r[RW-1] ^ word[i];
				r  = r << 1;
				if (fb)
					r = r ^ tail_a;
			end
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Input register (s1) and result register (s2)
	// ------------------------------------------------------------------
	logic                             v_s1;
	logic [crc_cw_pkg::BYTE_BITS-1:0] byte_s1;
	logic                             v_s2;
	crc_cw_pkg::cw_result_t           res_s2;
	logic                             adv_s2;

	assign adv_s2     = !v_s2 || cw_ready;
	assign byte_ready = !v_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (byte_ready)
				v_s1 <= byte_valid;
			if (adv_s2)
				v_s2 <= v_s1;
		end
	end

	// Codeword datapath, s1 -> s2
	logic [crc_cw_pkg::BYTE_BITS-1:0] word_hi;
	logic [crc_cw_pkg::BYTE_BITS-1:0] word_lo;
	logic [RW-1:0]                    rem_hi;
	logic [RW-1:0]                    rem_lo;
	logic [CW-1:0]                    cw_hi;
	logic [CW-1:0]                    cw_lo;
	logic [5:0]                       len_full;
	crc_cw_pkg::cw_result_t           res_d;

	always_comb begin
		// byte mode takes the whole byte; nibble mode splits it
		if (dataword_mode_q == crc_cw_pkg::MODE_BYTE) begin
			word_hi = byte_s1;
			word_lo = '0;
		end else begin
			word_hi = {4'h0, byte_s1[7:4]};
			word_lo = {4'h0, byte_s1[3:0]};
		end
		rem_hi = div_rem(word_hi, dataword_mode_q == crc_cw_pkg::MODE_NIBBLE, tail_al) >> align_sh;
		rem_lo = div_rem(word_lo, 1'b1, tail_al) >> align_sh;
		cw_hi  = (CW'(word_hi) << deg_eff) | CW'(rem_hi);
		cw_lo  = (CW'(word_lo) << deg_eff) | CW'(rem_lo);

		if (dataword_mode_q == crc_cw_pkg::MODE_BYTE)
			len_full = 6'(crc_cw_pkg::BYTE_BITS) + 6'(deg_eff);
		else
			len_full = 6'(crc_cw_pkg::NIBBLE_BITS) + 6'(deg_eff);

		res_d.first_codeword  = crc_cw_pkg::FIRST_W'(cw_hi);
		res_d.second_valid    = (dataword_mode_q == crc_cw_pkg::MODE_NIBBLE);
		res_d.second_codeword = res_d.second_valid ? crc_cw_pkg::SECOND_W'(cw_lo) : '0;
		res_d.codeword_length = len_full[crc_cw_pkg::LEN_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready)
			byte_s1 <= data_byte;
		if (v_s1 && adv_s2)
			res_s2 <= res_d;
	end

	assign cw_valid        = v_s2;
	assign first_codeword  = res_s2.first_codeword;
	assign second_codeword = res_s2.second_codeword;
	assign second_valid    = res_s2.second_valid;
	assign codeword_length = res_s2.codeword_length;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_ready |=> v_s1)
		else $error("accepted byte did not reach the input register");

	a_full_pipe_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && v_s2 && !cw_ready |-> !byte_ready)
		else $error("byte taken while both stages are full and stalled");

	a_s1_moves_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && adv_s2 |=> v_s2)
		else $error("input register advanced without filling the result register");

	a_second_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cw_valid && !second_valid |-> second_codeword == '0)
		else $error("second codeword not zero in 8-bit mode");

endmodule

// ===== tb/crc_codeword_encoder_test.sv =====
`timescale 1ns / 1ps

module crc_codeword_encoder_test;

	// Index just past the register list: writes there must be dropped
	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam int MAX_DEG    = crc_cw_pkg::MAX_DEGREE_DEF;
	localparam int SEGMENTS   = 35;
	localparam int SEG_BYTES  = 50;
	localparam int SHOW_LIMIT = 40;
	localparam int PROBE_N    = 20;

	logic                                clk;
	logic                                arst_n     = 1'b0;
	logic                                byte_valid = 1'b0;
	logic                                byte_ready;
	logic [crc_cw_pkg::BYTE_BITS-1:0]    data_byte  = '0;
	logic                                cw_valid;
	logic                                cw_ready   = 1'b0;
	logic [crc_cw_pkg::FIRST_W-1:0]      first_codeword;
	logic [crc_cw_pkg::SECOND_W-1:0]     second_codeword;
	logic                                second_valid;
	logic [crc_cw_pkg::LEN_W-1:0]        codeword_length;
	logic                                psel       = 1'b0;
	logic                                penable    = 1'b0;
	logic                                pwrite     = 1'b0;
	logic [crc_cw_pkg::PADDR_W-1:0]      paddr      = '0;
	logic [crc_cw_pkg::PDATA_W-1:0]      pwdata     = '0;
	logic [crc_cw_pkg::PDATA_W-1:0]      prdata;
	logic                                pready;

	crc_codeword_encoder uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.byte_valid      (byte_valid),
		.byte_ready      (byte_ready),
		.data_byte       (data_byte),
		.cw_valid        (cw_valid),
		.cw_ready        (cw_ready),
		.first_codeword  (first_codeword),
		.second_codeword (second_codeword),
		.second_valid    (second_valid),
		.codeword_length (codeword_length),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready)
	);

	// Shadow copy of the register file, as the block should hold it
	logic [crc_cw_pkg::TAIL_W-1:0] gen_tail   = crc_cw_pkg::TAIL_RST;
	logic [crc_cw_pkg::DEG_W-1:0]  gen_degree = crc_cw_pkg::DEGREE_RST;
	logic                          word_mode  = crc_cw_pkg::MODE_RST;

	// Codewords still owed by the block, oldest first
	crc_cw_pkg::cw_result_t owed_codewords[$];

	int errors        = 0;
	int send_idle_pct = 25;
	int recv_idle_pct = 58;

	// Directed requests. Register setting per row; a row whose codeword is plain from
	// the arithmetic has it typed in, the rest go through the model.
	typedef struct {
		logic [crc_cw_pkg::TAIL_W-1:0]    tail;
		logic [crc_cw_pkg::DEG_W-1:0]     degree;
		logic                             dw_mode;
		logic [crc_cw_pkg::BYTE_BITS-1:0] data;
		bit                               pinned;
		crc_cw_pkg::cw_result_t           want;
	} probe_row_t;

	probe_row_t probes [PROBE_N] = '{
		// reset setting: x^3+x^2+x+1, one 8-bit dataword; zero byte gives zero codeword
		'{16'h0007, 5'd3, crc_cw_pkg::MODE_BYTE, 8'h00, 1'b1,
			{24'h000000, 20'h00000, 1'b0, 5'd11}},
		'{16'h0007, 5'd3, crc_cw_pkg::MODE_BYTE, 8'hFF, 1'b0, '0},
		'{16'h0007, 5'd3, crc_cw_pkg::MODE_BYTE, 8'h80, 1'b0, '0},
		'{16'h0007, 5'd3, crc_cw_pkg::MODE_NIBBLE, 8'h00, 1'b1,
			{24'h000000, 20'h00000, 1'b1, 5'd7}},
		'{16'h0007, 5'd3, crc_cw_pkg::MODE_NIBBLE, 8'hFF, 1'b0, '0},
		'{16'h0007, 5'd3, crc_cw_pkg::MODE_NIBBLE, 8'h5A, 1'b0, '0},
		// degree zero acts as x+1: remainder is the parity bit
		'{16'h0001, 5'd0, crc_cw_pkg::MODE_BYTE, 8'hFF, 1'b1,
			{24'h0001FE, 20'h00000, 1'b0, 5'd9}},
		// tail bits above the degree are masked off
		'{16'hFFFF, 5'd0, crc_cw_pkg::MODE_BYTE, 8'h80, 1'b1,
			{24'h000101, 20'h00000, 1'b0, 5'd9}},
		'{16'hFFFF, 5'd0, crc_cw_pkg::MODE_NIBBLE, 8'hF1, 1'b1,
			{24'h00001E, 20'h00003, 1'b1, 5'd5}},
		// x^16 alone: remainder always zero, codeword is the shifted dataword
		'{16'h0000, 5'd16, crc_cw_pkg::MODE_BYTE, 8'hFF, 1'b1,
			{24'hFF0000, 20'h00000, 1'b0, 5'd24}},
		// degree beyond the maximum saturates
		'{16'h0000, 5'd31, crc_cw_pkg::MODE_BYTE, 8'hA5, 1'b1,
			{24'hA50000, 20'h00000, 1'b0, 5'd24}},
		'{16'h0000, 5'd16, crc_cw_pkg::MODE_NIBBLE, 8'hA5, 1'b1,
			{24'h0A0000, 20'h50000, 1'b1, 5'd20}},
		'{16'hFFFF, 5'd16, crc_cw_pkg::MODE_BYTE, 8'hFF, 1'b0, '0},
		'{16'hFFFF, 5'd16, crc_cw_pkg::MODE_BYTE, 8'h01, 1'b0, '0},
		'{16'hFFFF, 5'd16, crc_cw_pkg::MODE_NIBBLE, 8'hFF, 1'b0, '0},
		'{16'h1021, 5'd16, crc_cw_pkg::MODE_BYTE, 8'h31, 1'b0, '0},
		'{16'h1021, 5'd17, crc_cw_pkg::MODE_NIBBLE, 8'h8C, 1'b0, '0},
		'{16'h8005, 5'd16, crc_cw_pkg::MODE_BYTE, 8'h80, 1'b0, '0},
		'{16'h0003, 5'd1, crc_cw_pkg::MODE_BYTE, 8'hFF, 1'b0, '0},
		'{16'h0007, 5'd3, crc_cw_pkg::MODE_BYTE, 8'hFF, 1'b0, '0}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block wedges
	initial begin
		#5_000_000;
		$display("[crc_codeword_encoder] ERROR");
		$finish;
	end

	task automatic report(input string msg);
		errors++;
		if (errors <= SHOW_LIMIT)
			$display("mismatch: %s", msg);
	endtask

	// Systematic codeword: dataword MSB first through the LFSR-style long division,
	// remainder appended below the dataword.
	function automatic logic [31:0] systematic_cw(input logic [7:0] word, input int nbits,
			input int deg);
		logic [31:0] mask;
		logic [31:0] poly;
		logic [31:0] rem;
		logic        fb;
		mask = (32'd1 << deg) - 32'd1;
		poly = {16'b0, gen_tail} & mask;
		rem  = '0;
		for (int i = nbits - 1; i >= 0; i--) begin
			fb  = rem[deg-1] ^ word[i];
			rem = (rem << 1) & mask;
			if (fb)
				rem ^= poly;
		end
		return ({24'b0, word} << deg) | rem;
	endfunction

	function automatic crc_cw_pkg::cw_result_t predict_codewords(
			input logic [crc_cw_pkg::BYTE_BITS-1:0] value);
		int                     deg;
		crc_cw_pkg::cw_result_t r;
		deg = int'(gen_degree);
		if (deg < 1)
			deg = 1;
		if (deg > MAX_DEG)
			deg = MAX_DEG;
		r = '0;
		if (word_mode == crc_cw_pkg::MODE_BYTE) begin
			r.first_codeword  = crc_cw_pkg::FIRST_W'(
				systematic_cw(value, crc_cw_pkg::BYTE_BITS, deg));
			r.codeword_length = crc_cw_pkg::LEN_W'(crc_cw_pkg::BYTE_BITS + deg);
		end else begin
			r.first_codeword  = crc_cw_pkg::FIRST_W'(
				systematic_cw({4'b0, value[7:4]}, crc_cw_pkg::NIBBLE_BITS, deg));
			r.second_codeword = crc_cw_pkg::SECOND_W'(
				systematic_cw({4'b0, value[3:0]}, crc_cw_pkg::NIBBLE_BITS, deg));
			r.second_valid    = 1'b1;
			r.codeword_length = crc_cw_pkg::LEN_W'(crc_cw_pkg::NIBBLE_BITS + deg);
		end
		return r;
	endfunction

	// Receiver: random back-pressure, one update per edge
	always @(posedge clk)
		cw_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

	// Result checker; everything sampled is the pre-edge value
	always @(posedge clk) begin
		crc_cw_pkg::cw_result_t exp;
		if (arst_n && cw_valid && cw_ready) begin
			if (owed_codewords.size() == 0) begin
				report($sformatf("codeword %h with nothing outstanding", first_codeword));
			end else begin
				exp = owed_codewords.pop_front();
				if (first_codeword !== exp.first_codeword)
					report($sformatf("first_codeword %h, want %h",
						first_codeword, exp.first_codeword));
				if (second_codeword !== exp.second_codeword)
					report($sformatf("second_codeword %h, want %h",
						second_codeword, exp.second_codeword));
				if (second_valid !== exp.second_valid)
					report($sformatf("second_valid %b, want %b",
						second_valid, exp.second_valid));
				if (codeword_length !== exp.codeword_length)
					report($sformatf("codeword_length %0d, want %0d",
						codeword_length, exp.codeword_length));
			end
		end
	end

	// Present one byte request, holding it until taken. Valid is only dropped for a gap,
	// so back-to-back requests never see a 0-then-1 in the same step.
	task automatic send_byte(input logic [crc_cw_pkg::BYTE_BITS-1:0] value, input bit pinned,
			input crc_cw_pkg::cw_result_t pinned_want);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		data_byte  <= value;
		do
			@(posedge clk);
		while (!byte_ready);
		owed_codewords.insert(owed_codewords.size(),
			pinned ? pinned_want : predict_codewords(value));
	endtask

	// One APB transfer: setup, access, then an idle step with psel low
	task automatic apb_access(input logic wr, input logic [1:0] idx,
			input logic [crc_cw_pkg::PDATA_W-1:0] wdata,
			output logic [crc_cw_pkg::PDATA_W-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rdata = prdata;
		if (wr) begin
			case (idx)
				crc_cw_pkg::REG_TAIL:   gen_tail   = wdata[crc_cw_pkg::TAIL_W-1:0];
				crc_cw_pkg::REG_DEGREE: gen_degree = wdata[crc_cw_pkg::DEG_W-1:0];
				crc_cw_pkg::REG_MODE:   word_mode  = wdata[0];
				default:                ;
			endcase
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Reprogram once the pipe is empty. Upper data bits are junk on purpose; a stray
	// write to the unused index must not disturb anything. Read back to confirm.
	task automatic apply_setting(input logic [crc_cw_pkg::TAIL_W-1:0] tail,
			input logic [crc_cw_pkg::DEG_W-1:0] degree, input logic dw_mode);
		logic [crc_cw_pkg::PDATA_W-1:0] rd;
		byte_valid <= 1'b0;
		while (owed_codewords.size() != 0)
			@(posedge clk);
		// let the pipe settle before reprogramming
		repeat (2) @(posedge clk);
		apb_access(1'b1, crc_cw_pkg::REG_TAIL,   {16'($urandom), tail}, rd);
		apb_access(1'b1, crc_cw_pkg::REG_DEGREE, {27'($urandom), degree}, rd);
		apb_access(1'b1, crc_cw_pkg::REG_MODE,   {31'($urandom), dw_mode}, rd);
		apb_access(1'b1, REG_SPARE,  $urandom, rd);
		apb_access(1'b0, crc_cw_pkg::REG_TAIL, '0, rd);
		if (rd !== {16'b0, gen_tail})
			report($sformatf("tail reads %h, want %h", rd, gen_tail));
		apb_access(1'b0, crc_cw_pkg::REG_DEGREE, '0, rd);
		if (rd !== {27'b0, gen_degree})
			report($sformatf("degree reads %h, want %h", rd, gen_degree));
		apb_access(1'b0, crc_cw_pkg::REG_MODE, '0, rd);
		if (rd !== {31'b0, word_mode})
			report($sformatf("mode reads %h, want %h", rd, word_mode));
	endtask

	initial begin
		logic [crc_cw_pkg::TAIL_W-1:0] tail;
		logic [crc_cw_pkg::DEG_W-1:0]  degree;
		int                            drain;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table; a row only triggers reprogramming when its setting changes
		for (int i = 0; i < PROBE_N; i++) begin
			if (probes[i].tail != gen_tail || probes[i].degree != gen_degree ||
					probes[i].dw_mode != word_mode)
				apply_setting(probes[i].tail, probes[i].degree, probes[i].dw_mode);
			send_byte(probes[i].data, probes[i].pinned, probes[i].want);
		end

		// Random blocks: slow sender / busy receiver, then swapped, then flat out
		for (int s = 0; s < SEGMENTS; s++) begin
			if (s < 12) begin
				send_idle_pct = 25;
				recv_idle_pct = 58;
			end else if (s < 24) begin
				send_idle_pct = 58;
				recv_idle_pct = 25;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			// lean on the clamps now and then, mostly in-range degrees
			case ($urandom_range(0, 7))
				0:       degree = '0;
				1:       degree = crc_cw_pkg::DEG_W'(MAX_DEG);
				2:       degree = crc_cw_pkg::DEG_W'($urandom_range(MAX_DEG + 1, 31));
				default: degree = crc_cw_pkg::DEG_W'($urandom_range(1, MAX_DEG));
			endcase
			case ($urandom_range(0, 5))
				0:       tail = '0;
				1:       tail = '1;
				default: tail = crc_cw_pkg::TAIL_W'($urandom);
			endcase
			apply_setting(tail, degree, 1'($urandom_range(0, 1)));
			for (int k = 0; k < SEG_BYTES; k++)
				send_byte(8'($urandom), 1'b0, '0);
		end

		byte_valid <= 1'b0;
		for (drain = 0; drain < 2000 && owed_codewords.size() != 0; drain++)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (owed_codewords.size() != 0)
			report($sformatf("%0d codewords never arrived", owed_codewords.size()));

		if (errors == 0)
			$display("[crc_codeword_encoder] OK");
		else
			$display("[crc_codeword_encoder] ERROR");
		$finish;
	end

endmodule
